@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CHK_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle rule");

// Next-cycle implication, disabled while in reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle rule");

`endif

@@ rtl/rtpp_pkg.sv @@
// Types and constants of the RTP payload packetizer.
package rtpp_pkg;

    localparam int FRAME_W         = 20;
    localparam int SEQ_W           = 16;
    localparam int TS_W            = 32;
    localparam int SSRC_W          = 32;
    localparam int PT_W            = 7;
    localparam int HDR_LEN         = 12;
    localparam int HDR_IDX_W       = 4;
    localparam int CHUNK_BYTES_DEF = 1024;
    localparam int QUEUE_DEPTH     = 4;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    // Version 2, no padding, no extension, no CSRCs.
    localparam logic [7:0] RTP_BYTE0 = 8'h80;

    typedef enum logic {
        REG_SSRC = 1'b0,
        REG_PT   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]         data_byte;
        logic [FRAME_W-1:0] frame_length;
        logic [TS_W-1:0]    media_time;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_header;
        logic       packet_end;
        logic       frame_end;
        logic       run_last;
    } out_item_t;

    // One classified byte, handed from the front to the back.
    typedef struct packed {
        logic [7:0]       data_byte;
        logic [TS_W-1:0]  media_time;
        logic [SEQ_W-1:0] seq_num;
        logic             need_hdr;
        logic             marker;
        logic             packet_end;
        logic             frame_end;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic [SSRC_W-1:0] ssrc;
        logic [PT_W-1:0]   kind;
    } cfg_t;

endpackage

@@ rtl/rtpp_regs.sv @@
// APB configuration registers: SSRC and payload type.
module rtpp_regs
    import rtpp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [SSRC_W-1:0] ssrc_reg;
    logic [PT_W-1:0]   kind_reg;
    reg_idx_t          reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssrc_reg <= '0;
            kind_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SSRC: ssrc_reg <= pwdata[SSRC_W-1:0];
                REG_PT:   kind_reg <= pwdata[PT_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SSRC: prdata = APB_DATA_W'(ssrc_reg);
            REG_PT:   prdata = APB_DATA_W'(kind_reg);
            default:  prdata = '0;
        endcase
    end

    assign cfg.ssrc = ssrc_reg;
    assign cfg.kind = kind_reg;

endmodule

@@ rtl/rtpp_front.sv @@
// Front end: takes payload beats, tracks frame and packet offsets, classifies each byte.
module rtpp_front
    import rtpp_pkg::*;
#(
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    input  q_status_t q_stat,
    output logic      push,
    output q_entry_t  push_entry
);

    localparam int CHUNK_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

    logic [SEQ_W-1:0]   seq_reg,   seq_next;
    logic [FRAME_W-1:0] foff_reg,  foff_next;
    logic [CHUNK_W-1:0] coff_reg,  coff_next;

    logic [FRAME_W:0]   foff_plus1;
    logic [FRAME_W+1:0] foff_plus_chunk;
    logic               last_of_frame;
    logic               last_of_chunk;
    logic               need_hdr;
    logic               marker;
    logic [SEQ_W-1:0]   seq_inc;

    assign item_stall = q_stat.full;
    assign push       = item_valid && !q_stat.full;

    // remaining <= 1  <=>  length <= offset + 1 (also covers offset past length)
    assign foff_plus1      = {1'b0, foff_reg} + (FRAME_W+1)'(1);
    assign last_of_frame   = {1'b0, item.frame_length} <= foff_plus1;
    assign foff_plus_chunk = {2'b00, foff_reg} + (FRAME_W+2)'(CHUNK_BYTES);
    assign marker          = {2'b00, item.frame_length} <= foff_plus_chunk;
    assign last_of_chunk   = coff_reg == CHUNK_W'(CHUNK_BYTES - 1);
    assign need_hdr        = coff_reg == '0;
    assign seq_inc         = seq_reg + SEQ_W'(1);

    always_comb
    begin
        push_entry.data_byte  = item.data_byte;
        push_entry.media_time = item.media_time;
        push_entry.seq_num    = seq_inc;
        push_entry.need_hdr   = need_hdr;
        push_entry.marker     = marker;
        push_entry.packet_end = last_of_frame || last_of_chunk;
        push_entry.frame_end  = last_of_frame;
    end

    always_comb
    begin
        seq_next  = seq_reg;
        foff_next = foff_reg;
        coff_next = coff_reg;
        if (push)
        begin
            if (need_hdr)
            begin
                seq_next = seq_inc;
            end
            if (last_of_frame)
            begin
                foff_next = '0;
                coff_next = '0;
            end
            else
            begin
                foff_next = foff_plus1[FRAME_W-1:0];
                coff_next = last_of_chunk ? '0 : coff_reg + CHUNK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg  <= '0;
            foff_reg <= '0;
            coff_reg <= '0;
        end
        else
        begin
            seq_reg  <= seq_next;
            foff_reg <= foff_next;
            coff_reg <= coff_next;
        end
    end

endmodule

@@ rtl/rtpp_queue.sv @@
// Short FIFO of classified bytes between the front and the back.
module rtpp_queue
    import rtpp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  push_entry,
    input  logic      pop,
    output q_entry_t  head,
    output q_status_t q_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t           slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    assign q_stat.empty = count_reg == '0;
    assign q_stat.full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign head         = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/rtpp_back.sv @@
// Back end: expands each queued byte into header beats plus the payload beat.
module rtpp_back
    import rtpp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_entry_t  head,
    input  q_status_t q_stat,
    input  cfg_t      cfg,
    output logic      pop,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    logic [HDR_IDX_W-1:0] idx_reg, idx_next;
    logic                 valid_reg, valid_next;
    out_item_t            beat_reg, beat_next;
    logic                 load;
    logic                 payload_beat;
    logic [7:0]           hdr_byte;

    assign load         = !q_stat.empty && (!valid_reg || !result_stall);
    assign payload_beat = !head.need_hdr || (idx_reg == HDR_IDX_W'(HDR_LEN));
    assign pop          = load && payload_beat;

    always_comb
    begin
        case (idx_reg)
            4'd0:    hdr_byte = RTP_BYTE0;
            4'd1:    hdr_byte = {head.marker, cfg.kind};
            4'd2:    hdr_byte = head.seq_num[15:8];
            4'd3:    hdr_byte = head.seq_num[7:0];
            4'd4:    hdr_byte = head.media_time[31:24];
            4'd5:    hdr_byte = head.media_time[23:16];
            4'd6:    hdr_byte = head.media_time[15:8];
            4'd7:    hdr_byte = head.media_time[7:0];
            4'd8:    hdr_byte = cfg.ssrc[31:24];
            4'd9:    hdr_byte = cfg.ssrc[23:16];
            4'd10:   hdr_byte = cfg.ssrc[15:8];
            4'd11:   hdr_byte = cfg.ssrc[7:0];
            default: hdr_byte = RTP_BYTE0;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        beat_next  = beat_reg;
        if (load)
        begin
            valid_next = 1'b1;
            if (payload_beat)
            begin
                idx_next             = '0;
                beat_next.out_byte   = head.data_byte;
                beat_next.is_header  = 1'b0;
                beat_next.packet_end = head.packet_end;
                beat_next.frame_end  = head.frame_end;
                beat_next.run_last   = 1'b1;
            end
            else
            begin
                idx_next             = idx_reg + HDR_IDX_W'(1);
                beat_next.out_byte   = hdr_byte;
                beat_next.is_header  = 1'b1;
                beat_next.packet_end = 1'b0;
                beat_next.frame_end  = 1'b0;
                beat_next.run_last   = 1'b0;
            end
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign result_valid = valid_reg;
    assign result       = beat_reg;

endmodule

@@ rtl/rtp_payload_packetizer.sv @@
// Top level of the RTP payload packetizer.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------
//  item     | item_valid / item_stall     | data_byte, frame_length, media_time
//  result   | result_valid / result_stall | out_byte, is_header, packet_end,
//           |                             | frame_end, run_last
//  config   | psel/penable/pwrite, pready | paddr, pwdata, prdata
//
// A byte that opens a packet yields 13 output beats (12 header + payload), any
// other byte one beat; the output register emits one beat per cycle unless stalled.
// The front takes one byte per cycle while the 4-entry queue has room.
// An accepted byte goes into the queue, then into the back end's output register.
// Reset clears offsets, sequence number, queue and output valid; no clearing pass.
// A stalled result holds; the front keeps taking bytes until the queue fills.
module rtp_payload_packetizer
    import rtpp_pkg::*;
#(
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  in_item_t              item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output out_item_t             result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t      cfg;
    q_status_t q_stat;
    q_entry_t  push_entry;
    q_entry_t  head;
    logic      push;
    logic      pop;

    rtpp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rtpp_front #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    rtpp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    rtpp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_stat       (q_stat),
        .cfg          (cfg),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ rtl/rtpp_checker.sv @@
// Port-level checks for the RTP payload packetizer, bound to the top level.
`include "assert_macros.svh"

module rtpp_checker
    import rtpp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      result_valid,
    input logic      result_stall,
    input out_item_t result,
    input logic      pready
);

    `CHK_NEXT(a_stall_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))
    `CHK_SAME(a_hdr_flags, clk, rst_n, result_valid && result.is_header, !result.packet_end && !result.frame_end && !result.run_last)
    `CHK_SAME(a_payload_last, clk, rst_n, result_valid && !result.is_header, result.run_last)
    `CHK_SAME(a_frame_pkt_end, clk, rst_n, result_valid && result.frame_end, result.packet_end && pready)

endmodule

bind rtp_payload_packetizer rtpp_checker u_rtpp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .pready       (pready)
);
